/* design/bpq_pkg.sv */
package bpq_pkg;

	localparam int unsigned CAP_W = 7;
	localparam int unsigned OCC_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd50;

	// register indexes on the configuration port
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_POP    = 2'd1,
		FUNC_PEEK   = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_DUP   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_EVAL   = 2'd1,
		S_COMMIT = 2'd2
	} state_t;

	// commands broadcast to every cell of the chain
	typedef struct packed {
		logic eval;
		logic ins;
		logic pop;
	} cell_ctrl_t;

endpackage

/* design/bounded_priority_queue_unique_keys_top.sv */
// a request is accepted, then the cells compare it in the eval state and the
// result is registered in the commit state; a new request is accepted only in
// idle or together with the commit, so one transaction at a time passes the cell
// chain; a waiting result holds the commit and the next accept
// reset: arst_n clears the fill count, the control state and the output valid and
// sets the capacity register to 50; entry contents are left as they are
module bounded_priority_queue_unique_keys_top #(
	parameter int unsigned DEPTH     = 64,
	parameter int unsigned KEY_BITS  = 16,
	parameter int unsigned PRIO_BITS = 8,
	localparam int unsigned IN_W     = ((KEY_BITS + PRIO_BITS + 7) / 8) * 8,
	localparam int unsigned OUT_W    = ((KEY_BITS + PRIO_BITS + bpq_pkg::OCC_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// request stream
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // item_key, item_priority, zero fill
	input  logic [1:0]       s_axis_tuser,  // func
	// result stream
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,  // head_key, head_priority, occupancy, zero fill
	output logic [1:0]       m_axis_tuser,  // status
	// configuration port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > bpq_pkg::CAP_W) ? CNT_W : bpq_pkg::CAP_W;

	// control state
	bpq_pkg::state_t     state_q, state_nxt;
	logic [CNT_W-1:0]    count_q;
	logic [bpq_pkg::CAP_W-1:0] cap_q;

	// request held while the chain works on it
	bpq_pkg::func_t      req_func_q;
	logic [KEY_BITS-1:0] req_key_q;
	logic [PRIO_BITS-1:0] req_prio_q;

	// result register
	logic                      m_valid_q;
	bpq_pkg::status_t          out_status_q;
	logic [KEY_BITS-1:0]       out_key_q;
	logic [PRIO_BITS-1:0]      out_prio_q;
	logic [bpq_pkg::OCC_W-1:0] out_occ_q;

	// result of the request in the commit cycle
	bpq_pkg::status_t          res_status;
	logic [KEY_BITS-1:0]       res_key;
	logic [PRIO_BITS-1:0]      res_prio;
	logic [bpq_pkg::OCC_W-1:0] res_occ;

	logic                 in_accept;
	logic                 out_free;
	logic                 commit;
	logic                 full;
	logic                 dup;
	logic                 empty;
	bpq_pkg::cell_ctrl_t  ctrl;

	// cell chain wiring, one entry per cell
	logic [KEY_BITS-1:0]  cell_key  [DEPTH];
	logic [PRIO_BITS-1:0] cell_prio [DEPTH];
	logic [DEPTH-1:0]     cell_ge;
	logic [DEPTH-1:0]     cell_match;
	logic [DEPTH-1:0]     cell_valid;

	// ---------------------------------------------------------------
	// configuration port: single capacity register, always ready
	// ---------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bpq_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == bpq_pkg::REG_CAPACITY)) begin
			cap_q <= pwdata[bpq_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == bpq_pkg::REG_CAPACITY) begin
			prdata = 32'(cap_q);
		end
	end

	// ---------------------------------------------------------------
	// sequencing: idle -> eval (cells sample flags) -> commit
	// ---------------------------------------------------------------
	// the result slot is free if empty or being drained this cycle
	assign out_free  = !m_valid_q || m_axis_tready;
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign commit    = (state_q == bpq_pkg::S_COMMIT) && out_free;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bpq_pkg::S_IDLE: begin
				if (in_accept) begin
					state_nxt = bpq_pkg::S_EVAL;
				end
			end
			bpq_pkg::S_EVAL: begin
				state_nxt = bpq_pkg::S_COMMIT;
			end
			bpq_pkg::S_COMMIT: begin
				if (out_free) begin
					state_nxt = in_accept ? bpq_pkg::S_EVAL : bpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = bpq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// full is checked before the duplicate search; limit saturates at DEPTH
	assign full  = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (count_q == CNT_W'(DEPTH));
	assign dup   = |cell_match;
	assign empty = (count_q == '0);

	always_comb begin
		s_axis_tready = 1'b0;
		ctrl          = '0;
		unique case (state_q)
			bpq_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
			end
			bpq_pkg::S_EVAL: begin
				ctrl.eval = 1'b1;
			end
			bpq_pkg::S_COMMIT: begin
				// next request may enter on the same edge as this commit
				s_axis_tready = out_free;
				ctrl.ins = out_free && (req_func_q == bpq_pkg::FUNC_INSERT) && !full && !dup;
				ctrl.pop = out_free && (req_func_q == bpq_pkg::FUNC_POP) && !empty;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_func_q <= bpq_pkg::func_t'(s_axis_tuser);
			req_key_q  <= s_axis_tdata[KEY_BITS-1:0];
			req_prio_q <= s_axis_tdata[KEY_BITS +: PRIO_BITS];
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.ins) begin
			count_q <= count_q + 1'b1;
		end else if (ctrl.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// cell chain, cell 0 holds the head
	// ---------------------------------------------------------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                 l_ge;
		logic [KEY_BITS-1:0]  l_key;
		logic [PRIO_BITS-1:0] l_prio;
		logic [KEY_BITS-1:0]  r_key;
		logic [PRIO_BITS-1:0] r_prio;

		assign cell_valid[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			// the new item lands in the head cell if nothing stays ahead of it
			assign l_ge   = 1'b1;
			assign l_key  = '0;
			assign l_prio = '0;
		end else begin : g_inner
			assign l_ge   = cell_ge[i-1];
			assign l_key  = cell_key[i-1];
			assign l_prio = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_key  = '0;
			assign r_prio = '0;
		end else begin : g_notlast
			assign r_key  = cell_key[i+1];
			assign r_prio = cell_prio[i+1];
		end

		bpq_cell #(
			.KEY_BITS  (KEY_BITS),
			.PRIO_BITS (PRIO_BITS)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.valid      (cell_valid[i]),
			.req_key    (req_key_q),
			.req_prio   (req_prio_q),
			.left_ge    (l_ge),
			.left_key   (l_key),
			.left_prio  (l_prio),
			.right_key  (r_key),
			.right_prio (r_prio),
			.key        (cell_key[i]),
			.prio       (cell_prio[i]),
			.ge         (cell_ge[i]),
			.match      (cell_match[i])
		);
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// result fields from the state before the commit takes effect
	always_comb begin
		res_status = bpq_pkg::ST_OK;
		res_key    = '0;
		res_prio   = '0;
		res_occ    = bpq_pkg::OCC_W'(count_q);
		case (req_func_q) inside
			bpq_pkg::FUNC_INSERT: begin
				if (full) begin
					res_status = bpq_pkg::ST_FULL;
				end else if (dup) begin
					res_status = bpq_pkg::ST_DUP;
				end else begin
					res_occ = bpq_pkg::OCC_W'(count_q + 1'b1);
				end
			end
			bpq_pkg::FUNC_POP, bpq_pkg::FUNC_PEEK: begin
				if (empty) begin
					res_status = bpq_pkg::ST_EMPTY;
				end else begin
					res_key  = cell_key[0];
					res_prio = cell_prio[0];
					if (req_func_q == bpq_pkg::FUNC_POP) begin
						res_occ = bpq_pkg::OCC_W'(count_q - 1'b1);
					end
				end
			end
			default: begin
				res_status = bpq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_status_q <= res_status;
			out_key_q    <= res_key;
			out_prio_q   <= res_prio;
			out_occ_q    <= res_occ;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = OUT_W'({out_occ_q, out_prio_q, out_key_q});

`ifndef SYNTH
	// the fill count never passes the number of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count beyond depth");

	// insert and pop never reach the cells together
	a_ctrl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.ins && ctrl.pop))
		else $error("insert and pop issued together");

	// while a result waits, nothing has committed since, so its occupancy is current
	a_occ_current: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (out_occ_q == bpq_pkg::OCC_W'(count_q)))
		else $error("pending occupancy differs from fill count");

	// the fill count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1)
			|| (count_q == $past(count_q) - 1'b1)))
		else $error("fill count jumped");
`endif

endmodule

/* design/bpq_cell.sv */
module bpq_cell #(
	parameter int unsigned KEY_BITS  = 16,
	parameter int unsigned PRIO_BITS = 8
) (
	input  logic                   clk,
	input  bpq_pkg::cell_ctrl_t    ctrl,
	input  logic                   valid,
	input  logic [KEY_BITS-1:0]    req_key,
	input  logic [PRIO_BITS-1:0]   req_prio,
	input  logic                   left_ge,
	input  logic [KEY_BITS-1:0]    left_key,
	input  logic [PRIO_BITS-1:0]   left_prio,
	input  logic [KEY_BITS-1:0]    right_key,
	input  logic [PRIO_BITS-1:0]   right_prio,
	output logic [KEY_BITS-1:0]    key,
	output logic [PRIO_BITS-1:0]   prio,
	output logic                   ge,
	output logic                   match
);

	logic [KEY_BITS-1:0]  key_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic                 ge_q;
	logic                 match_q;

	// flags sampled against the pending request
	always_ff @(posedge clk) begin
		if (ctrl.eval) begin
			ge_q    <= valid && (prio_q >= req_prio);
			match_q <= valid && (key_q == req_key);
		end
	end

	// insert: stay if ahead of the new item, take it at the boundary,
	// otherwise take the left neighbour; pop: take the right neighbour
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!ge_q) begin
				if (left_ge) begin
					key_q  <= req_key;
					prio_q <= req_prio;
				end else begin
					key_q  <= left_key;
					prio_q <= left_prio;
				end
			end
		end else if (ctrl.pop) begin
			key_q  <= right_key;
			prio_q <= right_prio;
		end
	end

	assign key   = key_q;
	assign prio  = prio_q;
	assign ge    = ge_q;
	assign match = match_q;

endmodule

/* tb/sv/tb_bounded_priority_queue_unique_keys_top.sv */
module tb_bounded_priority_queue_unique_keys_top;
	import bpq_pkg::*;

	localparam int unsigned QDEPTH      = 64;
	localparam int unsigned KEY_W       = 16;
	localparam int unsigned PRIO_W      = 8;
	localparam int unsigned IN_W        = ((KEY_W + PRIO_W + 7) / 8) * 8;
	localparam int unsigned OUT_W       = ((KEY_W + PRIO_W + OCC_W + 7) / 8) * 8;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 200;

	// one request as it travels on the input stream
	typedef struct packed {
		func_t             func;
		logic [KEY_W-1:0]  key;
		logic [PRIO_W-1:0] prio;
	} request_t;

	// one result as it is expected on the output stream
	typedef struct packed {
		status_t           status;
		logic [KEY_W-1:0]  key;
		logic [PRIO_W-1:0] prio;
		logic [OCC_W-1:0]  occ;
	} outcome_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata  = '0;  // item_key, item_priority
	logic [1:0]        s_axis_tuser  = '0;  // func
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;        // head_key, head_priority, occupancy, zero fill
	logic [1:0]        m_axis_tuser;        // status
	logic              psel          = 1'b0;
	logic              penable       = 1'b0;
	logic              pwrite        = 1'b0;
	logic [2:0]        paddr         = '0;
	logic [31:0]       pwdata        = '0;
	logic [31:0]       prdata;
	logic              pready;

	// shadow of the queue contents, head at index 0
	logic [KEY_W-1:0]  shadow_keys  [QDEPTH];
	logic [PRIO_W-1:0] shadow_prios [QDEPTH];
	int unsigned       shadow_fill     = 0;
	logic [CAP_W-1:0]  shadow_capacity = CAP_RESET;

	request_t          request_backlog[$];   // requests not yet on the bus
	outcome_t          awaited_outcomes[$];  // results predicted, oldest first
	logic [KEY_W-1:0]  recent_keys[$];       // keys recently queued for insert, to provoke duplicates
	request_t          next_request;
	outcome_t          oldest_outcome;
	int unsigned       send_gap      = 0;
	int unsigned       stall_left    = 0;
	logic              sender_idles   = 1'b0;
	logic              receiver_idles = 1'b0;
	int                mismatch_count = 0;

	bounded_priority_queue_unique_keys_top #(
		.DEPTH     (QDEPTH),
		.KEY_BITS  (KEY_W),
		.PRIO_BITS (PRIO_W)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// apply one request to the shadow queue and return the result it must give
	function automatic outcome_t serve_request(func_t func, logic [KEY_W-1:0] key,
			logic [PRIO_W-1:0] prio);
		outcome_t    res;
		int unsigned room;
		int unsigned slot;
		int unsigned idx;
		logic        seen;
		res.status = ST_OK;
		res.key    = '0;
		res.prio   = '0;
		case (func)
			FUNC_INSERT: begin
				// the limit saturates at the physical depth
				room = (shadow_capacity > QDEPTH) ? QDEPTH : shadow_capacity;
				seen = 1'b0;
				for (idx = 0; idx < shadow_fill; idx++)
					if (shadow_keys[idx] == key)
						seen = 1'b1;
				// full is tested before duplicate
				if (shadow_fill >= room) begin
					res.status = ST_FULL;
				end else if (seen) begin
					res.status = ST_DUP;
				end else begin
					// behind every entry of equal or higher priority
					slot = 0;
					while (slot < shadow_fill && shadow_prios[slot] >= prio)
						slot++;
					for (idx = shadow_fill; idx > slot; idx--) begin
						shadow_keys[idx]  = shadow_keys[idx-1];
						shadow_prios[idx] = shadow_prios[idx-1];
					end
					shadow_keys[slot]  = key;
					shadow_prios[slot] = prio;
					shadow_fill++;
				end
			end
			FUNC_POP, FUNC_PEEK: begin
				if (shadow_fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.key  = shadow_keys[0];
					res.prio = shadow_prios[0];
					if (func == FUNC_POP) begin
						for (idx = 1; idx < shadow_fill; idx++) begin
							shadow_keys[idx-1]  = shadow_keys[idx];
							shadow_prios[idx-1] = shadow_prios[idx];
						end
						shadow_fill--;
					end
				end
			end
			default: ;  // unused code leaves the queue alone
		endcase
		res.occ = OCC_W'(shadow_fill);
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// request side: predict on every accepted transaction, then load the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				awaited_outcomes.push_back(serve_request(func_t'(s_axis_tuser),
					s_axis_tdata[KEY_W-1:0], s_axis_tdata[KEY_W+PRIO_W-1:KEY_W]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap      <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (request_backlog.size() != 0) begin
					next_request = request_backlog.pop_front();
					s_axis_tuser  <= next_request.func;
					s_axis_tdata  <= {next_request.prio, next_request.key};
					s_axis_tvalid <= 1'b1;
					// a burst of idle cycles once this transaction has gone
					if (sender_idles && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 13);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side: compare each accepted transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_outcomes.size() == 0) begin
					$error("result with no request outstanding: status %0d", m_axis_tuser);
					mismatch_count++;
				end else begin
					oldest_outcome = awaited_outcomes.pop_front();
					check_field("status", 32'(oldest_outcome.status), 32'(m_axis_tuser));
					check_field("head_key", 32'(oldest_outcome.key),
						32'(m_axis_tdata[KEY_W-1:0]));
					check_field("head_priority", 32'(oldest_outcome.prio),
						32'(m_axis_tdata[KEY_W+PRIO_W-1:KEY_W]));
					check_field("occupancy", 32'(oldest_outcome.occ),
						32'(m_axis_tdata[KEY_W+PRIO_W+OCC_W-1:KEY_W+PRIO_W]));
				end
			end
			// back-pressure comes in random bursts while receiver idling is on
			if (stall_left != 0) begin
				stall_left    <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
				stall_left    <= $urandom_range(0, 12);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// setup then access cycle; the register takes the value on the access edge
	task automatic set_capacity(input logic [CAP_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_CAPACITY, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow_capacity = value;
	endtask

	task automatic push_request(input func_t func, input logic [KEY_W-1:0] key,
			input logic [PRIO_W-1:0] prio);
		request_t req;
		req.func = func;
		req.key  = key;
		req.prio = prio;
		request_backlog.push_back(req);
	endtask

	// waits until every request has been sent and every transaction answered, then lets the block settle
	task automatic wait_until_drained();
		do @(negedge clk);
		while (request_backlog.size() != 0 || s_axis_tvalid || awaited_outcomes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// a run of random requests leaning towards inserts or towards removals
	task automatic queue_random_run(input int unsigned count, input int unsigned insert_pct);
		request_t    req;
		int unsigned n;
		int unsigned pick;
		for (n = 0; n < count; n++) begin
			pick     = $urandom_range(0, 99);
			req.key  = KEY_W'($urandom());
			req.prio = PRIO_W'($urandom());
			if (pick < insert_pct) begin
				req.func = FUNC_INSERT;
				// mostly a narrow key range so the queue fills with clashes
				pick = $urandom_range(0, 99);
				if (pick < 20 && recent_keys.size() != 0)
					req.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
				else if (pick < 75)
					req.key = KEY_W'($urandom_range(0, 127));
				// plenty of ties to exercise first-in-first-out among equal priorities
				pick = $urandom_range(0, 99);
				if (pick < 45)
					req.prio = PRIO_W'($urandom_range(0, 3));
				else if (pick < 55)
					req.prio = (pick < 50) ? '0 : '1;
				recent_keys.push_back(req.key);
				if (recent_keys.size() > 32)
					void'(recent_keys.pop_front());
			end else if (pick < insert_pct + ((100 - insert_pct) * 6) / 10) begin
				req.func = FUNC_POP;
			end else if (pick < 97) begin
				req.func = FUNC_PEEK;
			end else begin
				req.func = FUNC_NOP;
			end
			request_backlog.push_back(req);
		end
	endtask

	initial begin
		int unsigned      phase;
		int unsigned      queued;
		int unsigned      run_len;
		logic             filling;
		logic [CAP_W-1:0] cap;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: tiny capacity, empty queue, extreme fields
		set_capacity(7'd2);
		push_request(FUNC_POP,    16'h0000, 8'h00);  // pop on empty
		push_request(FUNC_PEEK,   16'hffff, 8'hff);  // peek on empty
		push_request(FUNC_INSERT, 16'h0000, 8'h00);
		push_request(FUNC_INSERT, 16'hffff, 8'hff);  // jumps to the head
		push_request(FUNC_INSERT, 16'h0000, 8'h0a);  // full and duplicate, full wins
		push_request(FUNC_PEEK,   16'h0000, 8'h00);
		push_request(FUNC_NOP,    16'ha5a5, 8'h5a);  // unused code
		push_request(FUNC_POP,    16'h0000, 8'h00);
		push_request(FUNC_INSERT, 16'h0000, 8'h07);  // duplicate key
		push_request(FUNC_INSERT, 16'h8001, 8'h00);  // tie, goes behind the older entry
		push_request(FUNC_POP,    16'h0000, 8'h00);
		push_request(FUNC_POP,    16'h0000, 8'h00);
		push_request(FUNC_POP,    16'h0000, 8'h00);  // empty again
		wait_until_drained();

		// zero capacity refuses every insert
		set_capacity(7'd0);
		push_request(FUNC_INSERT, 16'h1234, 8'h80);
		push_request(FUNC_PEEK,   16'h0000, 8'h00);
		wait_until_drained();

		// capacity above the depth, with ties behind a higher priority
		set_capacity(7'd127);
		push_request(FUNC_INSERT, 16'h0011, 8'hc8);
		push_request(FUNC_INSERT, 16'h0022, 8'hc8);
		push_request(FUNC_INSERT, 16'h0033, 8'hff);
		push_request(FUNC_POP,    16'h0000, 8'h00);
		push_request(FUNC_POP,    16'h0000, 8'h00);
		push_request(FUNC_POP,    16'h0000, 8'h00);
		wait_until_drained();

		// random phases, each setting its capacity first; the last one runs without idling
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: cap = 7'd1;
				1: cap = 7'd64;
				2: cap = 7'd100;
				3: cap = CAP_W'($urandom_range(4, 63));
				4: cap = 7'd3;
				5: cap = 7'd127;
				6: cap = 7'd50;
				default: cap = 7'd64;
			endcase
			sender_idles   = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
			receiver_idles = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
			set_capacity(cap);
			queued  = 0;
			filling = 1'b1;
			while (queued < PHASE_ITEMS) begin
				run_len = $urandom_range(20, 80);
				queue_random_run(run_len, filling ? 85 : 25);
				queued += run_len;
				filling = !filling;
			end
			wait_until_drained();
		end

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* filelist.f */
design/bpq_pkg.sv
design/bpq_cell.sv
design/bounded_priority_queue_unique_keys_top.sv
tb/sv/tb_bounded_priority_queue_unique_keys_top.sv
